// File: rtl/core/ema_pkg.sv
// constants, register codes and the voltage table of the energy meter accumulator
`default_nettype none
package ema_pkg;

  localparam int unsigned WINDOW_TICKS   = 60;
  localparam int unsigned CAL_SAVE_TICKS = 600;
  localparam int unsigned BACKUP_PERIOD  = 3600;

  localparam int unsigned RAW_W    = 24;
  localparam int unsigned SUM_W    = 30;
  localparam int unsigned WCNT_W   = 6;
  localparam int unsigned CCNT_W   = 10;
  localparam int unsigned BCNT_W   = 12;
  localparam int unsigned RATIO_W  = 8;
  localparam int unsigned VSEL_W   = 2;
  localparam int unsigned VOLT_W   = 9;
  localparam int unsigned PF_W     = 8;
  localparam int unsigned INIT_W   = 40;
  localparam int unsigned ENERGY_W = 64;
  localparam int unsigned CFG_W    = 40;
  localparam int unsigned IDX_W    = 2;

  // product of window sum, ratio, volts and power factor
  localparam int unsigned PROD_W = SUM_W + RATIO_W + VOLT_W + PF_W;
  localparam int unsigned DIV_W  = 28;
  localparam int unsigned STEP_W = 6;

  localparam logic [DIV_W-1:0] ENERGY_DIVISOR = DIV_W'(225000000);

  typedef enum logic [IDX_W-1:0] {
    REG_CT_RATIO       = 2'd0,
    REG_VOLT_SELECT    = 2'd1,
    REG_PF_PERCENT     = 2'd2,
    REG_INITIAL_ENERGY = 2'd3
  } reg_index_t;

  typedef enum logic [VSEL_W-1:0] {
    VSEL_220 = 2'd0,
    VSEL_380 = 2'd1,
    VSEL_460 = 2'd2
  } volt_sel_t;

  function automatic logic [VOLT_W-1:0] volts_of(input logic [VSEL_W-1:0] sel);
    logic [VOLT_W-1:0] v;
    case (sel)
      VSEL_380: v = VOLT_W'(380);
      VSEL_460: v = VOLT_W'(460);
      default:  v = VOLT_W'(220);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/energy_meter_accumulator.sv
// energy meter accumulator: tick handling, bit-serial multiply and divide, output register
//
// One tick reading is taken per transfer on the slave stream and gives one result on the
// master stream. A tick that does not close the window goes straight to the send state,
// which loads the result once the output is free. A tick that closes the window first runs
// 25 shift-add steps of the one-bit-per-cycle multiplier (8 for the ratio, 9 for the volts,
// 8 for the power factor) and 55 steps of the restoring divider, one quotient bit per cycle,
// then the output load. The next tick is taken once the previous result has been loaded into
// the output register. Writing initial_energy also loads the energy total at once.
`default_nettype none
module energy_meter_accumulator (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire  [23:0]                s_axis_tdata,  // irms_raw
  input  wire  [0:0]                 s_axis_tuser,  // cal_started
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [63:0]                m_axis_tdata,  // energy_total
  output logic [2:0]                 m_axis_tuser,  // window_closed, backup_save, cal_flash_save
  input  wire                        cfg_we,
  input  wire  [ema_pkg::IDX_W-1:0]  cfg_index,
  input  wire  [ema_pkg::CFG_W-1:0]  cfg_data
);
  import ema_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_SEND} state_t;
  typedef enum logic [1:0] {PH_RATIO, PH_VOLTS, PH_PF} mul_phase_t;

  state_t            state;
  mul_phase_t        phase;

  logic [RATIO_W-1:0]  ct_ratio;
  logic [VSEL_W-1:0]   volt_select;
  logic [PF_W-1:0]     pf_percent;
  logic [INIT_W-1:0]   initial_energy;

  logic [WCNT_W-1:0]   window_count;
  logic [SUM_W-1:0]    window_sum;
  logic [ENERGY_W-1:0] energy_acc;
  logic                cal_pending;
  logic [CCNT_W-1:0]   cal_count;
  logic [BCNT_W-1:0]   backup_count;

  logic                closed;
  logic                backup;
  logic                flash;

  logic [PROD_W-1:0]   mcand;
  logic [PROD_W-1:0]   prod;
  logic [VOLT_W-1:0]   mplier;
  logic [STEP_W-1:0]   step;
  logic [PROD_W-1:0]   dvd;
  logic [DIV_W-1:0]    rem;

  logic                accept;
  logic                cal_any;
  logic [CCNT_W-1:0]   cal_inc;
  logic                cal_hit;
  logic [SUM_W-1:0]    sum_inc;
  logic [WCNT_W-1:0]   wcnt_inc;
  logic                close_now;
  logic [BCNT_W-1:0]   bcnt_inc;
  logic                backup_now;

  logic [PROD_W-1:0]   prod_add;
  logic [DIV_W:0]      rem_sh;
  logic                q_bit;
  logic [DIV_W-1:0]    rem_next;
  logic [PROD_W-1:0]   dvd_next;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cal_any    = cal_pending || s_axis_tuser[0];
    cal_inc    = cal_count + CCNT_W'(1);
    cal_hit    = cal_any && (cal_inc == CCNT_W'(CAL_SAVE_TICKS));
    sum_inc    = window_sum + SUM_W'(s_axis_tdata);
    wcnt_inc   = window_count + WCNT_W'(1);
    close_now  = (wcnt_inc >= WCNT_W'(WINDOW_TICKS));
    bcnt_inc   = backup_count + BCNT_W'(1);
    backup_now = (bcnt_inc >= BCNT_W'(BACKUP_PERIOD));
  end

  always_comb begin
    prod_add = mplier[0] ? (prod + mcand) : prod;
    rem_sh   = {rem, dvd[PROD_W-1]};
    q_bit    = (rem_sh >= {1'b0, ENERGY_DIVISOR});
    rem_next = q_bit ? DIV_W'(rem_sh - {1'b0, ENERGY_DIVISOR}) : rem_sh[DIV_W-1:0];
    dvd_next = {dvd[PROD_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase          <= PH_RATIO;
      ct_ratio       <= RATIO_W'(1);
      volt_select    <= VSEL_220;
      pf_percent     <= PF_W'(65);
      initial_energy <= '0;
      window_count   <= '0;
      window_sum     <= '0;
      energy_acc     <= '0;
      cal_pending    <= 1'b0;
      cal_count      <= '0;
      backup_count   <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != ST_SEND) begin
        m_axis_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_CT_RATIO: begin
            if (cfg_data[RATIO_W-1:0] != '0) ct_ratio <= cfg_data[RATIO_W-1:0];
          end
          REG_VOLT_SELECT: begin
            if (cfg_data[VSEL_W-1:0] <= VSEL_460) volt_select <= cfg_data[VSEL_W-1:0];
          end
          REG_PF_PERCENT: begin
            pf_percent <= cfg_data[PF_W-1:0];
          end
          REG_INITIAL_ENERGY: begin
            initial_energy <= cfg_data[INIT_W-1:0];
            energy_acc     <= ENERGY_W'(cfg_data[INIT_W-1:0]);
          end
          default: begin
          end
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cal_any) begin
              cal_count   <= cal_hit ? '0 : cal_inc;
              cal_pending <= !cal_hit;
            end
            flash        <= cal_hit;
            backup       <= backup_now;
            backup_count <= backup_now ? '0 : bcnt_inc;
            closed       <= close_now;
            if (close_now) begin
              window_sum   <= '0;
              window_count <= '0;
              mcand        <= PROD_W'(sum_inc);
              prod         <= '0;
              mplier       <= VOLT_W'(ct_ratio);
              step         <= STEP_W'(RATIO_W);
              phase        <= PH_RATIO;
              state        <= ST_MUL;
            end else begin
              window_sum   <= sum_inc;
              window_count <= wcnt_inc;
              state        <= ST_SEND;
            end
          end
        end
        ST_MUL: begin
          if (step == STEP_W'(1)) begin
            mcand <= prod_add;
            prod  <= '0;
            case (phase)
              PH_RATIO: begin
                mplier <= volts_of(volt_select);
                step   <= STEP_W'(VOLT_W);
                phase  <= PH_VOLTS;
              end
              PH_VOLTS: begin
                mplier <= VOLT_W'(pf_percent);
                step   <= STEP_W'(PF_W);
                phase  <= PH_PF;
              end
              default: begin
                dvd   <= prod_add;
                rem   <= '0;
                step  <= STEP_W'(PROD_W);
                state <= ST_DIV;
              end
            endcase
          end else begin
            mcand  <= {mcand[PROD_W-2:0], 1'b0};
            mplier <= mplier >> 1;
            prod   <= prod_add;
            step   <= step - STEP_W'(1);
          end
        end
        ST_DIV: begin
          dvd  <= dvd_next;
          rem  <= rem_next;
          step <= step - STEP_W'(1);
          if (step == STEP_W'(1)) begin
            energy_acc <= energy_acc + ENERGY_W'(dvd_next);
            state      <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= energy_acc;
            m_axis_tuser  <= {flash, backup, closed};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_energy_source: assert property (@(posedge clk)
    !$stable(energy_acc) |-> $past(rst) || $past(state == ST_DIV) || $past(cfg_we))
    else $error("energy total changed outside divide end or config write");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < ENERGY_DIVISOR)
    else $error("divider remainder not below divisor");

  a_valid_from_send: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_SEND))
    else $error("result shown without send step");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> window_count < WCNT_W'(WINDOW_TICKS))
    else $error("window count past window length");
`endif

endmodule
`default_nettype wire
